// File: design/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// Command codes and the control bundle shared by the keystream generator and
// its key store.
// ----------------------------------------------------------------------------
package rc4_pkg;

    typedef enum logic [1:0] {
        FUNC_KEY_WRITE = 2'd0,
        FUNC_INIT      = 2'd1,
        FUNC_GENERATE  = 2'd2
    } t_func;

    // key store controls driven by the main sequencer
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic kp_clear;
        logic kp_step;
    } t_ks_ctl;

endpackage

// File: design/rc4_key_store.sv
// ----------------------------------------------------------------------------
// rc4_key_store
// Key byte memory with the cyclic key pointer used by the key schedule. The
// pointer wraps at the effective key length (zero taken as one, saturated at
// the store depth).
// ----------------------------------------------------------------------------
module rc4_key_store #(
    parameter int MAX_KEY_BYTES = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rc4_pkg::t_ks_ctl i_ctl,
    input  logic [7:0]       i_wr_addr,
    input  logic [7:0]       i_wr_data,
    input  logic [8:0]       i_key_length,
    output logic [7:0]       o_rd_data
);
    import rc4_pkg::*;

    localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    logic [7:0]    r_mem [MAX_KEY_BYTES];
    logic [KW-1:0] r_kp;
    logic [7:0]    r_rd_data;
    logic [8:0]    s_eff_len;
    logic [8:0]    s_kp_inc;
    logic          s_wr_ok;

    always_comb begin
        if (i_key_length == 9'd0) begin
            s_eff_len = 9'd1;
        end else if (i_key_length > 9'(MAX_KEY_BYTES)) begin
            s_eff_len = 9'(MAX_KEY_BYTES);
        end else begin
            s_eff_len = i_key_length;
        end
    end

    assign s_kp_inc = 9'(r_kp) + 9'd1;
    // writes beyond the store depth are dropped
    assign s_wr_ok  = ({1'b0, i_wr_addr} < 9'(MAX_KEY_BYTES));

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && s_wr_ok) begin
            r_mem[i_wr_addr[KW-1:0]] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[r_kp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= '0;
        end else if (i_ctl.kp_clear) begin
            r_kp <= '0;
        end else if (i_ctl.kp_step) begin
            if (s_kp_inc >= s_eff_len) begin
                r_kp <= '0;
            end else begin
                r_kp <= s_kp_inc[KW-1:0];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/rc4_keystream_generator.sv
// ----------------------------------------------------------------------------
// rc4_keystream_generator
// Generate: an accepted item passes ST_G_A, ST_G_B, ST_G_OUT and is registered;
// the next item is taken back in ST_IDLE, later while the last result is
// stalled. Key byte write: stored as accepted. Initialize: identity fill, then
// ST_K_RD, ST_K_ACC, ST_K_W1, ST_K_W2 per key schedule step, as set by the one
// read and one write port of the permutation memory. Reset clears the
// pointers and sets key length to 1; permutation and key store are not cleared.
// ----------------------------------------------------------------------------
module rc4_keystream_generator #(
    parameter int MAX_KEY_BYTES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_func,
    input  logic [7:0] i_key_index,
    input  logic [7:0] i_key_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_keystream_byte,
    input  logic       i_cfg_we,
    input  logic [8:0] i_cfg_wdata
);
    import rc4_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_K_RD,
        ST_K_ACC,
        ST_K_W1,
        ST_K_W2,
        ST_G_A,
        ST_G_B,
        ST_G_OUT
    } t_state;

    t_state     r_state;
    logic [7:0] r_sbox [256];
    logic [7:0] r_rdata;
    logic [7:0] r_i;
    logic [7:0] r_j;
    logic [7:0] r_acc;
    logic [7:0] r_tmp;
    logic [7:0] r_b;
    logic [7:0] r_t;
    logic [7:0] r_cnt;
    logic [7:0] r_out;
    logic       r_out_valid;
    logic [8:0] r_key_length;

    logic       s_accept;
    logic       s_we;
    logic [7:0] s_waddr;
    logic [7:0] s_wdata;
    logic       s_re;
    logic [7:0] s_raddr;
    logic [7:0] s_acc_sum;
    logic [7:0] s_j_sum;
    logic [7:0] s_fwd;
    logic [7:0] s_ks_rdata;
    t_ks_ctl    s_ks_ctl;

    assign s_accept  = (r_state == ST_IDLE) && i_valid;
    assign s_acc_sum = r_acc + r_rdata + s_ks_rdata;
    assign s_j_sum   = r_j + r_rdata;

    // S[i] and S[j] were just swapped; the output read saw the old contents
    always_comb begin
        if (r_t == r_j) begin
            s_fwd = r_tmp;
        end else if (r_t == r_i) begin
            s_fwd = r_b;
        end else begin
            s_fwd = r_rdata;
        end
    end

    always_comb begin
        s_we     = 1'b0;
        s_waddr  = r_cnt;
        s_wdata  = r_cnt;
        s_re     = 1'b0;
        s_raddr  = r_cnt;
        s_ks_ctl = '0;
        unique case (r_state)
            ST_IDLE: begin
                s_re    = s_accept && (i_func == FUNC_GENERATE);
                s_raddr = r_i + 8'd1;
                s_ks_ctl.wr_en    = s_accept && (i_func == FUNC_KEY_WRITE);
                s_ks_ctl.kp_clear = s_accept && (i_func == FUNC_INIT);
            end
            ST_FILL: begin
                s_we = 1'b1;
            end
            ST_K_RD: begin
                s_re           = 1'b1;
                s_ks_ctl.rd_en = 1'b1;
            end
            ST_K_ACC: begin
                s_re    = 1'b1;
                s_raddr = s_acc_sum;
            end
            ST_K_W1: begin
                s_we    = 1'b1;
                s_wdata = r_rdata;
            end
            ST_K_W2: begin
                s_we             = 1'b1;
                s_waddr          = r_acc;
                s_wdata          = r_tmp;
                s_ks_ctl.kp_step = 1'b1;
            end
            ST_G_A: begin
                s_re    = 1'b1;
                s_raddr = s_j_sum;
            end
            ST_G_B: begin
                s_we    = 1'b1;
                s_waddr = r_i;
                s_wdata = r_rdata;
                s_re    = 1'b1;
                s_raddr = r_tmp + r_rdata;
            end
            ST_G_OUT: begin
                s_we    = 1'b1;
                s_waddr = r_j;
                s_wdata = r_tmp;
            end
            default: begin
                s_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_sbox[s_waddr] <= s_wdata;
        end
        if (s_re) begin
            r_rdata <= r_sbox[s_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= 9'd1;
        end else if (i_cfg_we) begin
            r_key_length <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= 8'd0;
            r_j         <= 8'd0;
            r_cnt       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            // ST_G_OUT reloads the output itself when the old item drains
            if (r_out_valid && !i_stall && (r_state != ST_G_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (i_func == FUNC_INIT) begin
                            r_cnt   <= 8'd0;
                            r_state <= ST_FILL;
                        end else if (i_func == FUNC_GENERATE) begin
                            r_i     <= r_i + 8'd1;
                            r_state <= ST_G_A;
                        end
                    end
                end
                ST_FILL: begin
                    r_cnt <= r_cnt + 8'd1;
                    if (r_cnt == 8'hFF) begin
                        r_acc   <= 8'd0;
                        r_state <= ST_K_RD;
                    end
                end
                ST_K_RD: begin
                    r_state <= ST_K_ACC;
                end
                ST_K_ACC: begin
                    r_acc   <= s_acc_sum;
                    r_tmp   <= r_rdata;
                    r_state <= ST_K_W1;
                end
                ST_K_W1: begin
                    r_state <= ST_K_W2;
                end
                ST_K_W2: begin
                    r_cnt <= r_cnt + 8'd1;
                    if (r_cnt == 8'hFF) begin
                        r_i     <= 8'd0;
                        r_j     <= 8'd0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_K_RD;
                    end
                end
                ST_G_A: begin
                    r_tmp   <= r_rdata;
                    r_j     <= s_j_sum;
                    r_state <= ST_G_B;
                end
                ST_G_B: begin
                    r_b     <= r_rdata;
                    r_t     <= r_tmp + r_rdata;
                    r_state <= ST_G_OUT;
                end
                ST_G_OUT: begin
                    // wait here while the previous item is still unclaimed
                    if (!r_out_valid || !i_stall) begin
                        r_out       <= s_fwd;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    rc4_key_store #(
        .MAX_KEY_BYTES(MAX_KEY_BYTES)
    ) u_rc4_key_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (s_ks_ctl),
        .i_wr_addr    (i_key_index),
        .i_wr_data    (i_key_byte),
        .i_key_length (r_key_length),
        .o_rd_data    (s_ks_rdata)
    );

    assign o_stall          = (r_state != ST_IDLE);
    assign o_valid          = r_out_valid;
    assign o_keystream_byte = r_out;

endmodule
